// ----- design/largest_empty_square_finder_defines.svh -----
// Assertion macros shared by the largest empty square finder RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef LARGEST_EMPTY_SQUARE_FINDER_DEFINES_SVH
`define LARGEST_EMPTY_SQUARE_FINDER_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define LESF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define LESF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/lesf_pkg.sv -----
// Package of the largest empty square finder: constants, register codes and types.
// Depends on nothing; used by every module of the block but lesf_ram.
`default_nettype none

package lesf_pkg;

    // Default sizes of the map.
    localparam int MAX_COLS_DEF = 1024;
    localparam int MAX_ROWS_DEF = 1024;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    typedef logic [CFG_IDX_W-1:0] cfg_index_t;

    localparam cfg_index_t CFG_ROW_WIDTH     = 2'd0;
    localparam cfg_index_t CFG_EMPTY_CHAR    = 2'd1;
    localparam cfg_index_t CFG_OBSTACLE_CHAR = 2'd2;

    localparam logic [10:0] ROW_WIDTH_RST     = 11'd1;
    localparam logic [7:0]  EMPTY_CHAR_RST    = 8'd46;
    localparam logic [7:0]  OBSTACLE_CHAR_RST = 8'd111;

    // Control flags of the item held in the second pipeline stage.
    typedef struct packed {
        logic row_end;    // the cell closes its row
        logic on_border;  // first row or first column
        logic last;       // final cell of the map
        logic obstacle;   // matches the obstacle code
        logic bad_char;   // matches neither code
        logic fwd;        // the line store read is stale; take the last written side
    } s1_ctl_t;

    // One result item.
    typedef struct packed {
        logic [10:0] square_size;
        logic [9:0]  top_row;
        logic [9:0]  left_col;
        logic        map_error;
    } res_t;

endpackage

`default_nettype wire

// ----- design/lesf_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`default_nettype none

module lesf_ram #(
    parameter  int WIDTH  = 11,
    parameter  int DEPTH  = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // A read of the entry being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- design/lesf_scan.sv -----
// Scan stage: column and row counting, cell classification and line store read.
// Depends on lesf_pkg.
`default_nettype none

module lesf_scan #(
    parameter  int MAX_COLS = lesf_pkg::MAX_COLS_DEF,
    parameter  int MAX_ROWS = lesf_pkg::MAX_ROWS_DEF,
    localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic [7:0]       cell_char,
    input  wire logic             last_cell,
    input  wire logic [10:0]      row_width,
    input  wire logic [7:0]       empty_char,
    input  wire logic [7:0]       obstacle_char,
    output logic                  rd_en,
    output logic      [COL_W-1:0] rd_addr,
    output logic                  s1_valid,
    output lesf_pkg::s1_ctl_t     s1_ctl,
    output logic      [COL_W-1:0] s1_col,
    output logic      [ROW_W-1:0] s1_row
);

    localparam int WCNT_W = $clog2(MAX_COLS + 1);

    logic [COL_W-1:0]  col_count_reg, col_count_next;
    logic [ROW_W-1:0]  row_count_reg, row_count_next;
    logic              s1_valid_reg;
    lesf_pkg::s1_ctl_t s1_ctl_reg, s1_ctl_next;
    logic [COL_W-1:0]  s1_col_reg;
    logic [ROW_W-1:0]  s1_row_reg;

    logic [WCNT_W-1:0] w_eff;
    logic [COL_W-1:0]  col;
    logic [WCNT_W:0]   col_plus;
    logic              row_end;

    // Effective row width: zero acts as one, anything too wide as the maximum.
    always_comb
    begin
        if (row_width == 11'd0)
        begin
            w_eff = WCNT_W'(1);
        end
        else if (32'(row_width) > 32'(MAX_COLS))
        begin
            w_eff = WCNT_W'(MAX_COLS);
        end
        else
        begin
            w_eff = WCNT_W'(row_width);
        end
    end

    always_comb
    begin
        if (WCNT_W'(col_count_reg) >= w_eff)
        begin
            col = COL_W'(w_eff - WCNT_W'(1));
        end
        else
        begin
            col = col_count_reg;
        end
        col_plus = (WCNT_W + 1)'(col) + (WCNT_W + 1)'(1);
        row_end  = (col_plus >= {1'b0, w_eff});
    end

    always_comb
    begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (accept)
        begin
            if (last_cell)
            begin
                col_count_next = '0;
                row_count_next = '0;
            end
            else if (row_end)
            begin
                col_count_next = '0;
                if (32'(row_count_reg) < 32'(MAX_ROWS - 1))
                begin
                    row_count_next = row_count_reg + ROW_W'(1);
                end
            end
            else
            begin
                col_count_next = COL_W'(col_plus);
            end
        end
    end

    always_comb
    begin
        s1_ctl_next.row_end   = row_end;
        s1_ctl_next.on_border = (row_count_reg == '0) || (col == '0);
        s1_ctl_next.last      = last_cell;
        s1_ctl_next.obstacle  = (cell_char == obstacle_char);
        s1_ctl_next.bad_char  = (cell_char != obstacle_char) && (cell_char != empty_char);
        // The item now in the second stage writes this entry at this very edge.
        s1_ctl_next.fwd       = s1_valid_reg && (s1_col_reg == col);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            s1_valid_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ctl_reg <= s1_ctl_next;
            s1_col_reg <= col;
            s1_row_reg <= row_count_reg;
        end
    end

    assign rd_en    = accept;
    assign rd_addr  = col;
    assign s1_valid = s1_valid_reg;
    assign s1_ctl   = s1_ctl_reg;
    assign s1_col   = s1_col_reg;
    assign s1_row   = s1_row_reg;

endmodule

`default_nettype wire

// ----- design/lesf_dp.sv -----
// Square-size stage: computes each cell's side, writes it back, tracks the best square.
// Depends on lesf_pkg.
`default_nettype none

module lesf_dp #(
    parameter  int MAX_COLS = lesf_pkg::MAX_COLS_DEF,
    parameter  int MAX_ROWS = lesf_pkg::MAX_ROWS_DEF,
    localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int SIZE_W   = $clog2(MAX_COLS + 1)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s1_valid,
    input  wire lesf_pkg::s1_ctl_t s1_ctl,
    input  wire logic [COL_W-1:0]  s1_col,
    input  wire logic [ROW_W-1:0]  s1_row,
    input  wire logic [SIZE_W-1:0] rd_data,
    output logic                   wr_en,
    output logic      [COL_W-1:0]  wr_addr,
    output logic      [SIZE_W-1:0] wr_data,
    output logic                   res_valid,
    output lesf_pkg::res_t         res
);

    logic [SIZE_W-1:0] left_size_reg, left_size_next;
    logic [SIZE_W-1:0] diag_size_reg, diag_size_next;
    logic [SIZE_W-1:0] last_cur_reg;
    logic [SIZE_W-1:0] best_size_reg, best_size_next;
    logic [ROW_W-1:0]  best_row_reg, best_row_next;
    logic [COL_W-1:0]  best_col_reg, best_col_next;
    logic              error_seen_reg, error_seen_next;

    logic [SIZE_W-1:0] up;
    logic [SIZE_W-1:0] min_ul;
    logic [SIZE_W-1:0] min3;
    logic [SIZE_W-1:0] cur;
    logic              take_best;
    logic [SIZE_W-1:0] b_size;
    logic [ROW_W-1:0]  b_row;
    logic [COL_W-1:0]  b_col;
    logic              err_now;

    always_comb
    begin
        up     = s1_ctl.fwd ? last_cur_reg : rd_data;
        min_ul = (up < left_size_reg) ? up : left_size_reg;
        min3   = (min_ul < diag_size_reg) ? min_ul : diag_size_reg;
        if (s1_ctl.obstacle || s1_ctl.bad_char)
        begin
            cur = '0;
        end
        else if (s1_ctl.on_border)
        begin
            cur = SIZE_W'(1);
        end
        else
        begin
            cur = min3 + SIZE_W'(1);
        end
        take_best = (cur > best_size_reg);
        b_size    = take_best ? cur : best_size_reg;
        b_row     = take_best ? s1_row : best_row_reg;
        b_col     = take_best ? s1_col : best_col_reg;
        err_now   = error_seen_reg || s1_ctl.bad_char;
    end

    always_comb
    begin
        left_size_next  = left_size_reg;
        diag_size_next  = diag_size_reg;
        best_size_next  = best_size_reg;
        best_row_next   = best_row_reg;
        best_col_next   = best_col_reg;
        error_seen_next = error_seen_reg;
        if (s1_valid)
        begin
            if (s1_ctl.row_end || s1_ctl.last)
            begin
                left_size_next = '0;
                diag_size_next = '0;
            end
            else
            begin
                left_size_next = cur;
                diag_size_next = up;
            end
            if (s1_ctl.last)
            begin
                best_size_next  = '0;
                best_row_next   = '0;
                best_col_next   = '0;
                error_seen_next = 1'b0;
            end
            else
            begin
                best_size_next  = b_size;
                best_row_next   = b_row;
                best_col_next   = b_col;
                error_seen_next = err_now;
            end
        end
    end

    // Map result: size and corner are zero on error or when no empty cell exists.
    always_comb
    begin
        res.map_error = err_now;
        if (err_now || (b_size == '0))
        begin
            res.square_size = '0;
            res.top_row     = '0;
            res.left_col    = '0;
        end
        else
        begin
            res.square_size = 11'(b_size);
            if (32'(b_size) <= 32'(b_row) + 32'd1)
            begin
                res.top_row = 10'(32'(b_row) + 32'd1 - 32'(b_size));
            end
            else
            begin
                res.top_row = '0;
            end
            if (32'(b_size) <= 32'(b_col) + 32'd1)
            begin
                res.left_col = 10'(32'(b_col) + 32'd1 - 32'(b_size));
            end
            else
            begin
                res.left_col = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_size_reg  <= '0;
            diag_size_reg  <= '0;
            best_size_reg  <= '0;
            best_row_reg   <= '0;
            best_col_reg   <= '0;
            error_seen_reg <= 1'b0;
        end
        else
        begin
            left_size_reg  <= left_size_next;
            diag_size_reg  <= diag_size_next;
            best_size_reg  <= best_size_next;
            best_row_reg   <= best_row_next;
            best_col_reg   <= best_col_next;
            error_seen_reg <= error_seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid)
        begin
            last_cur_reg <= cur;
        end
    end

    assign wr_en     = s1_valid;
    assign wr_addr   = s1_col;
    assign wr_data   = cur;
    assign res_valid = s1_valid && s1_ctl.last;

endmodule

`default_nettype wire

// ----- design/lesf_out_buf.sv -----
// Two-entry result buffer: an output register with a skid register behind it.
// Depends on lesf_pkg.
`default_nettype none

module lesf_out_buf (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire lesf_pkg::res_t push_res,
    input  wire logic           out_stall,
    output logic                out_valid,
    output lesf_pkg::res_t      out_res,
    output logic [1:0]          level
);

    logic           out_valid_reg, out_valid_next;
    logic           skid_valid_reg, skid_valid_next;
    lesf_pkg::res_t out_res_reg, out_res_next;
    lesf_pkg::res_t skid_res_reg, skid_res_next;
    logic           pop;

    always_comb
    begin
        pop             = out_valid_reg && !out_stall;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_res_next    = out_res_reg;
        skid_res_next   = skid_res_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_res_next    = skid_res_reg;
                skid_valid_next = push;
                skid_res_next   = push_res;
            end
            else
            begin
                out_valid_next = push;
                out_res_next   = push_res;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_res_next   = push_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign level     = 2'(out_valid_reg) + 2'(skid_valid_reg);

endmodule

`default_nettype wire

// ----- design/largest_empty_square_finder.sv -----
// Top level of the largest empty square finder: configuration registers and glue.
// Depends on lesf_pkg, lesf_ram, lesf_scan, lesf_dp, lesf_out_buf and the defines header.
//
// Usage. Map cells arrive on the input channel (in_valid, in_stall, cell_char,
// last_cell), one character per item in row-major order. The item marked with
// last_cell yields one result item on the output channel (out_valid, out_stall,
// square_size, top_row, left_col, map_error); all other items yield none.
// Configuration (row width, empty and obstacle codes) is to be written through
// cfg_we, cfg_index and cfg_wdata while the block is idle; it does not enforce this.
// Throughput is one cell per clock cycle while in_stall is low, set by the single
// read and single write port of the line store, which is read in the cycle an item
// is taken and written in the next. A map's result reaches out_valid through the
// second stage and the result buffer. Reset clears the counters, the running best
// and the result buffer; the line store holds no reset value and needs no clearing
// pass, as an entry only decides a side once the row above has written it. Results
// wait in a two-entry buffer while the receiver stalls; in_stall rises only when that
// buffer with a result still in flight would leave no room for another, so a stream
// of single-cell maps cannot be taken at the full rate even while out_stall is low.
`default_nettype none
`include "largest_empty_square_finder_defines.svh"

module largest_empty_square_finder #(
    parameter int MAX_COLS = lesf_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = lesf_pkg::MAX_ROWS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire lesf_pkg::cfg_index_t          cfg_index,
    input  wire logic [lesf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [7:0]                    cell_char,
    input  wire logic                          last_cell,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [10:0]                   square_size,
    output logic      [9:0]                    top_row,
    output logic      [9:0]                    left_col,
    output logic                               map_error
);

    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int SIZE_W = $clog2(MAX_COLS + 1);

    // Configuration registers.
    logic [10:0] row_width_reg, row_width_next;
    logic [7:0]  empty_char_reg, empty_char_next;
    logic [7:0]  obstacle_char_reg, obstacle_char_next;

    logic              in_accept;
    logic              rd_en;
    logic [COL_W-1:0]  rd_addr;
    logic [SIZE_W-1:0] rd_data;
    logic              wr_en;
    logic [COL_W-1:0]  wr_addr;
    logic [SIZE_W-1:0] wr_data;
    logic              s1_valid;
    lesf_pkg::s1_ctl_t s1_ctl;
    logic [COL_W-1:0]  s1_col;
    logic [ROW_W-1:0]  s1_row;
    logic              res_valid;
    lesf_pkg::res_t    res;
    lesf_pkg::res_t    out_res;
    logic [1:0]        buf_level;

    always_comb
    begin
        row_width_next     = row_width_reg;
        empty_char_next    = empty_char_reg;
        obstacle_char_next = obstacle_char_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                lesf_pkg::CFG_ROW_WIDTH:     row_width_next     = cfg_wdata;
                lesf_pkg::CFG_EMPTY_CHAR:    empty_char_next    = cfg_wdata[7:0];
                lesf_pkg::CFG_OBSTACLE_CHAR: obstacle_char_next = cfg_wdata[7:0];
                default:                     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg     <= lesf_pkg::ROW_WIDTH_RST;
            empty_char_reg    <= lesf_pkg::EMPTY_CHAR_RST;
            obstacle_char_reg <= lesf_pkg::OBSTACLE_CHAR_RST;
        end
        else
        begin
            row_width_reg     <= row_width_next;
            empty_char_reg    <= empty_char_next;
            obstacle_char_reg <= obstacle_char_next;
        end
    end

    // A map's result needs a free buffer entry when its last cell reaches the
    // second stage, so the buffer level plus any result in flight must stay below two.
    assign in_stall  = (3'(buf_level) + 3'(s1_valid && s1_ctl.last)) >= 3'd2;
    assign in_accept = in_valid && !in_stall;

    lesf_scan #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (in_accept),
        .cell_char     (cell_char),
        .last_cell     (last_cell),
        .row_width     (row_width_reg),
        .empty_char    (empty_char_reg),
        .obstacle_char (obstacle_char_reg),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .s1_valid      (s1_valid),
        .s1_ctl        (s1_ctl),
        .s1_col        (s1_col),
        .s1_row        (s1_row)
    );

    // Line store: the square sides of the row above, one entry per column.
    lesf_ram #(
        .WIDTH (SIZE_W),
        .DEPTH (MAX_COLS)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    lesf_dp #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_valid  (s1_valid),
        .s1_ctl    (s1_ctl),
        .s1_col    (s1_col),
        .s1_row    (s1_row),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .res_valid (res_valid),
        .res       (res)
    );

    lesf_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_res  (res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_res   (out_res),
        .level     (buf_level)
    );

    assign square_size = out_res.square_size;
    assign top_row     = out_res.top_row;
    assign left_col    = out_res.left_col;
    assign map_error   = out_res.map_error;

    // A result arriving at a full buffer must meet an entry leaving it.
    `LESF_ASSERT_IMP(a_buf_no_overflow, clk, rst_n, res_valid && (buf_level == 2'd2),
        out_valid && !out_stall, "result buffer overflow")

    // Every result comes from a last cell taken at the edge before.
    `LESF_ASSERT_NXT(a_result_origin, clk, rst_n, !(in_accept && last_cell),
        !res_valid, "result without a last cell")

    // Forwarding is only ever asked for right behind another item.
    `LESF_ASSERT_NXT(a_fwd_after_item, clk, rst_n, !s1_valid,
        !(s1_valid && s1_ctl.fwd), "line store forwarding without a preceding item")

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking testbench of the largest empty square finder: directed maps, then random maps.
// It predicts every result from its own copy of the scan state and compares each result item.
// Depends on lesf_pkg and the largest_empty_square_finder top level only.
`default_nettype none

module tb;

    // Sizes of the block as built here, taken from the package defaults.
    localparam int LINE_CELLS = lesf_pkg::MAX_COLS_DEF;
    localparam int ROW_LIMIT  = lesf_pkg::MAX_ROWS_DEF;

    // Register index that the block does not decode; a write to it must change nothing.
    localparam lesf_pkg::cfg_index_t CFG_UNUSED = 2'd3;

    // Edges waited after the last awaited result; this leaves a comfortable margin.
    localparam int SETTLE_CYCLES   = 6;
    // Length of the long receiver hold-off that fills the block up.
    localparam int HOLD_OFF_CYCLES = 300;
    // Cycles without any accepted item before the run is declared hung.
    localparam int WATCHDOG_LIMIT  = 2000;
    // Rough number of cells sent by the random part.
    localparam int RANDOM_CELLS    = 400;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_we;
    lesf_pkg::cfg_index_t            cfg_index;
    logic [lesf_pkg::CFG_DATA_W-1:0] cfg_wdata;
    logic                            in_valid;
    logic                            in_stall;
    logic [7:0]                      cell_char;
    logic                            last_cell;
    logic                            out_valid;
    logic                            out_stall;
    logic [10:0]                     square_size;
    logic [9:0]                      top_row;
    logic [9:0]                      left_col;
    logic                            map_error;

    // Shared test controls, written by the main sequence; the result check also counts failures.
    bit idle_on      = 1'b1;
    int holds_wanted = 0;
    int cells_sent   = 0;
    int failures     = 0;

    // Results that the predictor has worked out and the block has not yet delivered.
    lesf_pkg::res_t awaited_squares[$];

    // The predictor's copy of the configuration.
    logic [10:0] width_setting;
    logic [7:0]  empty_setting;
    logic [7:0]  obstacle_setting;

    // The predictor's copy of the scan state: the previous row of square sides, the
    // left and up-left neighbours, the scan position and the best square so far.
    logic [10:0] line_sides [LINE_CELLS];
    logic [10:0] left_side;
    logic [10:0] diag_side;
    logic [9:0]  scan_col;
    logic [9:0]  scan_row;
    logic [10:0] best_side;
    logic [9:0]  best_row;
    logic [9:0]  best_col;
    logic        bad_seen;

    largest_empty_square_finder i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cell_char  (cell_char),
        .last_cell  (last_cell),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .square_size(square_size),
        .top_row    (top_row),
        .left_col   (left_col),
        .map_error  (map_error)
    );

    // Clock with a period of 20 units.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Length of the next idle stretch: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Returns the scan state to the start of a fresh map. The line store is left alone,
    // since the first row of every map overwrites it before it is used.
    task automatic clear_scan();
        left_side = '0;
        diag_side = '0;
        scan_col  = '0;
        scan_row  = '0;
        best_side = '0;
        best_row  = '0;
        best_col  = '0;
        bad_seen  = 1'b0;
    endtask

    // Advances the predictor by one accepted cell. On the cell that closes the map it
    // queues the square that the block must report, then clears for the next map.
    task automatic track_square(input logic [7:0] ch, input logic last);
        logic [10:0]    w;
        logic [10:0]    up;
        logic [10:0]    side;
        logic [10:0]    span;
        logic [9:0]     col;
        lesf_pkg::res_t found;
        w = width_setting;
        if (w == 0)
            w = 11'd1;
        if (w > LINE_CELLS)
            w = 11'(LINE_CELLS);
        // A width that shrank below the current column closes the row at its new end.
        if ({1'b0, scan_col} >= w)
            scan_col = 10'(w - 11'd1);
        col = scan_col;
        up  = line_sides[col];

        // Obstacles win over empties when both codes are the same; anything else is bad.
        if (ch == obstacle_setting)
            side = '0;
        else if (ch != empty_setting)
        begin
            bad_seen = 1'b1;
            side     = '0;
        end
        else if (scan_row == 0 || col == 0)
            side = 11'd1;
        else
        begin
            side = (up < left_side) ? up : left_side;
            side = (side < diag_side) ? side : diag_side;
            side = side + 11'd1;
        end

        // Strictly greater, so the first maximum in scan order is kept.
        if (side > best_side)
        begin
            best_side = side;
            best_row  = scan_row;
            best_col  = col;
        end

        line_sides[col] = side;
        diag_side       = up;
        left_side       = side;

        if ({1'b0, col} + 11'd1 >= w)
        begin
            scan_col  = '0;
            left_side = '0;
            diag_side = '0;
            if (scan_row < ROW_LIMIT - 1)
                scan_row = scan_row + 10'd1;
        end
        else
            scan_col = col + 10'd1;

        if (last)
        begin
            found           = '0;
            found.map_error = bad_seen;
            if (!bad_seen && best_side != 0)
            begin
                found.square_size = best_side;
                // A corner that would fall before the map edge is reported as zero.
                span = {1'b0, best_row} + 11'd1;
                if (best_side <= span)
                begin
                    span          = span - best_side;
                    found.top_row = span[9:0];
                end
                span = {1'b0, best_col} + 11'd1;
                if (best_side <= span)
                begin
                    span           = span - best_side;
                    found.left_col = span[9:0];
                end
            end
            awaited_squares.push_back(found);
            clear_scan();
        end
    endtask

    // Writes one register and mirrors it in the predictor. The enable is lowered after
    // the write edge and the task returns only at a later edge, so back-to-back writes
    // never assign the enable twice in the same step.
    task automatic write_reg(input lesf_pkg::cfg_index_t idx,
                             input logic [lesf_pkg::CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            lesf_pkg::CFG_ROW_WIDTH:     width_setting    = value;
            lesf_pkg::CFG_EMPTY_CHAR:    empty_setting    = value[7:0];
            lesf_pkg::CFG_OBSTACLE_CHAR: obstacle_setting = value[7:0];
            default:                     ;
        endcase
        @(posedge clk);
    endtask

    // Sets both character codes; the spare upper bits of the write data carry noise,
    // which the block must ignore.
    task automatic set_codes(input logic [7:0] empty_code, input logic [7:0] obstacle_code);
        write_reg(lesf_pkg::CFG_EMPTY_CHAR, {3'($urandom), empty_code});
        write_reg(lesf_pkg::CFG_OBSTACLE_CHAR, {3'($urandom), obstacle_code});
    endtask

    // Offers one cell after a random gap and waits until the block takes it. Valid is
    // left high on return, so a following item with no gap is presented at once.
    task automatic send_cell(input logic [7:0] ch, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        cell_char <= ch;
        last_cell <= last;
        do
            @(posedge clk);
        while (in_stall);
        track_square(ch, last);
        cells_sent++;
    endtask

    // Sends a run of cells written as text; the final one closes the map if asked.
    task automatic send_text(input string cells, input bit ends_map);
        int k;
        for (k = 0; k < cells.len(); k++)
            send_cell(cells[k], ends_map && (k == cells.len() - 1));
    endtask

    // Withdraws the input, waits for every awaited result and then lets the pipeline
    // run empty, so that registers may be written safely afterwards.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited_squares.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // The reset values of the registers: each cell is a row of its own.
    task automatic test_reset_defaults();
        send_text(".o.", 1'b1);
        // A write to the undecoded index must leave every register as it was.
        wait_idle();
        write_reg(CFG_UNUSED, '1);
        send_text("o..", 1'b1);
        wait_idle();
    endtask

    // Plain maps: a square in the middle, no square at all, a tie and an early end.
    task automatic test_plain_maps();
        write_reg(lesf_pkg::CFG_ROW_WIDTH, 11'd5);
        send_text(".o.........o....", 1'b0);
        send_text("....", 1'b1);
        send_text("oooooooooo", 1'b1);
        // Two equal squares: the first in scan order is the one reported.
        send_text("..o....o..", 1'b1);
        // The last mark in the middle of a row ends the map there.
        wait_idle();
        write_reg(lesf_pkg::CFG_ROW_WIDTH, 11'd4);
        send_text("......", 1'b1);
        send_text("........", 1'b1);
        wait_idle();
    endtask

    // Characters that match neither code, and the two codes made equal.
    task automatic test_bad_and_equal_codes();
        write_reg(lesf_pkg::CFG_ROW_WIDTH, 11'd3);
        send_text("....x....", 1'b1);
        send_text("......#", 1'b1);
        wait_idle();
        // With equal codes a matching cell is an obstacle and the old empty code is bad.
        set_codes("o", "o");
        send_text("ooo", 1'b1);
        send_text("oo.", 1'b1);
        wait_idle();
        set_codes(lesf_pkg::EMPTY_CHAR_RST, lesf_pkg::OBSTACLE_CHAR_RST);
    endtask

    // Character codes and cell characters at the ends of their range.
    task automatic test_code_extremes();
        write_reg(lesf_pkg::CFG_ROW_WIDTH, 11'd2);
        set_codes(8'hFF, 8'h00);
        send_cell(8'hFF, 1'b0);
        send_cell(8'hFF, 1'b0);
        send_cell(8'hFF, 1'b0);
        send_cell(8'hFF, 1'b1);
        send_cell(8'h00, 1'b0);
        send_cell(8'h7F, 1'b1);
        wait_idle();
        set_codes(8'h00, 8'hFF);
        send_cell(8'h00, 1'b0);
        send_cell(8'hFF, 1'b0);
        send_cell(8'h00, 1'b1);
        wait_idle();
        set_codes(lesf_pkg::EMPTY_CHAR_RST, lesf_pkg::OBSTACLE_CHAR_RST);
    endtask

    // A width of zero acts as one; the largest write value acts as the full line store.
    // One full row and two cells of the next show where the row really ends.
    task automatic test_width_extremes();
        write_reg(lesf_pkg::CFG_ROW_WIDTH, 11'd0);
        send_text("...", 1'b1);
        wait_idle();
        idle_on = 1'b0;
        write_reg(lesf_pkg::CFG_ROW_WIDTH, '1);
        repeat (LINE_CELLS + 1) send_cell(".", 1'b0);
        send_cell(".", 1'b1);
        wait_idle();
        idle_on = 1'b1;
    endtask

    // The width shrinks under a running map, so the next cell lands on the new last
    // column with neighbours from the old row; the reported column falls back to zero.
    task automatic test_width_shrink_mid_map();
        write_reg(lesf_pkg::CFG_ROW_WIDTH, 11'd8);
        send_text("................", 1'b0);
        send_text("..o..", 1'b0);
        wait_idle();
        write_reg(lesf_pkg::CFG_ROW_WIDTH, 11'd2);
        send_text(".", 1'b1);
        wait_idle();
    endtask

    // More rows than the row counter can hold: it stops at its top value, so the
    // single empty cell on the final row is reported on the top row index.
    task automatic test_row_saturation();
        idle_on = 1'b0;
        write_reg(lesf_pkg::CFG_ROW_WIDTH, 11'd1);
        repeat (ROW_LIMIT) send_cell("o", 1'b0);
        send_cell(".", 1'b1);
        wait_idle();
        idle_on = 1'b1;
    endtask

    // The receiver holds off for a long stretch while single-cell maps keep coming,
    // so the result buffer fills and the block has to stall its input.
    task automatic test_back_pressure();
        int k;
        write_reg(lesf_pkg::CFG_ROW_WIDTH, 11'd1);
        idle_on = 1'b0;
        holds_wanted++;
        for (k = 0; k < 40; k++)
            send_cell(k[0] ? "o" : ".", 1'b1);
        wait_idle();
        idle_on = 1'b1;
    endtask

    // Random maps: mostly well-formed rectangles of empties and obstacles with small
    // widths, some cut short, some with a width shrink in the middle, some pure noise.
    task automatic test_random_maps();
        int         goal;
        int         w;
        int         rows;
        int         last_k;
        int         shrink_k;
        int         empty_pct;
        int         k;
        int         r;
        bit         noisy;
        logic [7:0] ch;
        goal = cells_sent + RANDOM_CELLS;
        while (cells_sent < goal)
        begin
            // New settings only between maps and only once the block has gone quiet.
            if ($urandom_range(0, 9) < 4)
            begin
                wait_idle();
                r = $urandom_range(0, 9);
                if (r < 6)
                    set_codes(lesf_pkg::EMPTY_CHAR_RST, lesf_pkg::OBSTACLE_CHAR_RST);
                else if (r < 9)
                    set_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                else
                begin
                    ch = 8'($urandom_range(0, 255));
                    set_codes(ch, ch);
                end
                r = $urandom_range(0, 99);
                if (r < 2)
                    w = 0;
                else if (r < 72)
                    w = $urandom_range(1, 8);
                else if (r < 92)
                    w = $urandom_range(9, 40);
                else if (r < 98)
                    w = $urandom_range(41, 200);
                else
                    w = $urandom_range(201, 2047);
                write_reg(lesf_pkg::CFG_ROW_WIDTH, 11'(w));
            end
            w = (width_setting == 0) ? 1 :
                (width_setting > LINE_CELLS) ? LINE_CELLS : width_setting;
            rows = (w > 200) ? 1 : (w > 40) ? $urandom_range(1, 2) : $urandom_range(1, 8);
            last_k = w * rows - 1;
            if ($urandom_range(0, 9) == 0)
                last_k = $urandom_range(0, last_k);
            shrink_k  = ($urandom_range(0, 19) == 0) ? $urandom_range(0, last_k) : -1;
            noisy     = ($urandom_range(0, 9) == 0);
            empty_pct = $urandom_range(50, 97);
            idle_on   = ($urandom_range(0, 5) != 0);
            for (k = 0; k <= last_k; k++)
            begin
                // Never a widening: a wider row would read line store entries never written.
                if (k == shrink_k && k > 0)
                begin
                    wait_idle();
                    write_reg(lesf_pkg::CFG_ROW_WIDTH, 11'($urandom_range(0, w)));
                end
                r = $urandom_range(0, 99);
                if (noisy || r >= 99)
                    ch = 8'($urandom_range(0, 255));
                else if (r < empty_pct)
                    ch = empty_setting;
                else
                    ch = obstacle_setting;
                send_cell(ch, k == last_k);
            end
        end
        idle_on = 1'b1;
        wait_idle();
    endtask

    // Receiver: random stalls of random length with quiet stretches between them, and
    // the long hold-off whenever the main sequence asks for one.
    initial
    begin : result_receiver
        int holds_done;
        int quiet_left;
        int stall_len;
        holds_done = 0;
        quiet_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_done != holds_wanted)
            begin
                holds_done++;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (!idle_on || quiet_left > 0)
            begin
                if (quiet_left > 0)
                    quiet_left--;
                out_stall <= 1'b0;
            end
            else
            begin
                stall_len = pick_gap();
                if (stall_len > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (stall_len) @(posedge clk);
                end
                out_stall <= 1'b0;
                quiet_left = $urandom_range(0, 12);
            end
        end
    end

    // Compares every accepted result item, field by field, with the oldest awaited one.
    always @(posedge clk)
    begin : result_check
        lesf_pkg::res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_squares.size() == 0)
            begin
                $error("unexpected result: square_size %0d top_row %0d left_col %0d map_error %0b",
                       square_size, top_row, left_col, map_error);
                failures++;
            end
            else
            begin
                want = awaited_squares.pop_front();
                if (square_size !== want.square_size)
                begin
                    $error("square_size: expected %0d, actual %0d", want.square_size, square_size);
                    failures++;
                end
                if (top_row !== want.top_row)
                begin
                    $error("top_row: expected %0d, actual %0d", want.top_row, top_row);
                    failures++;
                end
                if (left_col !== want.left_col)
                begin
                    $error("left_col: expected %0d, actual %0d", want.left_col, left_col);
                    failures++;
                end
                if (map_error !== want.map_error)
                begin
                    $error("map_error: expected %0b, actual %0b", want.map_error, map_error);
                    failures++;
                end
            end
        end
    end

    // Watchdog: ends the run when neither channel has moved an item for too long.
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    // Main sequence: reset once, then the tests in turn, then the verdict.
    initial
    begin : main_sequence
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= lesf_pkg::CFG_ROW_WIDTH;
        cfg_wdata <= '0;
        in_valid  <= 1'b0;
        cell_char <= '0;
        last_cell <= 1'b0;

        width_setting    = lesf_pkg::ROW_WIDTH_RST;
        empty_setting    = lesf_pkg::EMPTY_CHAR_RST;
        obstacle_setting = lesf_pkg::OBSTACLE_CHAR_RST;
        foreach (line_sides[i])
            line_sides[i] = '0;
        clear_scan();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_plain_maps();
        test_bad_and_equal_codes();
        test_code_extremes();
        test_width_extremes();
        test_width_shrink_mid_map();
        test_row_saturation();
        test_back_pressure();
        test_random_maps();

        if (failures == 0 && awaited_squares.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

// ----- largest_empty_square_finder.f -----
+incdir+design
design/lesf_pkg.sv
design/lesf_ram.sv
design/lesf_scan.sv
design/lesf_dp.sv
design/lesf_out_buf.sv
design/largest_empty_square_finder.sv
tb/sv/tb.sv
